### rtl/sad_pkg.sv
// Shared constants and types for the sample averaging and calibration block.
// Holds field widths, register indexes, status codes and the calibration bundle.
// No dependencies.
`default_nettype none

package sad_pkg;

  localparam int SAMPLE_W   = 12;
  localparam int AVG_W      = 12;
  localparam int PCT_W      = 7;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 8;
  localparam int POINT_W    = 12;
  localparam int CFG_DATA_W = 12;
  localparam int CFG_IDX_W  = 3;
  localparam int NUM_W      = 19;

  localparam logic [PCT_W-1:0]   PCT_FULL      = 7'd100;
  localparam logic [COUNT_W-1:0] COUNT_DEFAULT = 8'd8;

  localparam logic [CFG_IDX_W-1:0] REG_SAMPLES   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_DRY       = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WET       = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DRY_VALID = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_WET_VALID = 3'd4;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_OK          = 2'd0,
    STATUS_NO_CAL      = 2'd1,
    STATUS_SAME_POINTS = 2'd2
  } status_t;

  typedef struct packed {
    logic [POINT_W-1:0] dry;
    logic [POINT_W-1:0] wet;
    logic               dry_valid;
    logic               wet_valid;
  } cal_t;

endpackage

`default_nettype wire

### rtl/sad_div.sv
// Restoring unsigned divider, one quotient bit per cycle.
// Uses widths from sad_pkg.
`default_nettype none

module sad_div
  import sad_pkg::*;
#(
  parameter int DW = 20
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               start,
  input  wire logic [DW-1:0]      dividend,
  input  wire logic [POINT_W-1:0] divisor,
  output logic                    done,
  output logic [DW-1:0]           quotient
);

  localparam int CNT_W = $clog2(DW + 1);

  logic               busy;
  logic [CNT_W-1:0]   cnt;
  logic [POINT_W-1:0] rem;
  logic [POINT_W-1:0] den;
  logic [POINT_W:0]   trial;
  logic [POINT_W:0]   diff;
  logic               ge;

  assign trial = {rem, quotient[DW-1]};
  assign ge    = trial >= {1'b0, den};
  assign diff  = trial - {1'b0, den};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy     <= 1'b1;
        cnt      <= CNT_W'(DW);
        quotient <= dividend;
        rem      <= '0;
        den      <= divisor;
      end else if (busy) begin
        quotient <= {quotient[DW-2:0], ge};
        rem      <= ge ? diff[POINT_W-1:0] : trial[POINT_W-1:0];
        cnt      <= cnt - CNT_W'(1);
        if (cnt == CNT_W'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sad_queue.sv
// Two-entry queue that decouples the accumulator from the arithmetic back end.
// Stand-alone; no package needed.
`default_nettype none

module sad_queue #(
  parameter int W = 28
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         wr_en,
  input  wire logic [W-1:0] wr_data,
  input  wire logic         rd_en,
  output logic [W-1:0]      rd_data,
  output logic              full,
  output logic              empty
);

  logic [W-1:0] mem [2];
  logic         wr_ptr;
  logic         rd_ptr;
  logic [1:0]   level;

  assign full    = level == 2'd2;
  assign empty   = level == 2'd0;
  assign rd_data = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_ptr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      level  <= 2'd0;
    end else begin
      if (wr_en) begin
        wr_ptr <= ~wr_ptr;
      end
      if (rd_en) begin
        rd_ptr <= ~rd_ptr;
      end
      if (wr_en && !rd_en) begin
        level <= level + 2'd1;
      end else if (rd_en && !wr_en) begin
        level <= level - 2'd1;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sad_front.sv
// Accumulator front end: sums samples and hands each completed batch to the queue.
// Depends on sad_pkg for field widths.
`default_nettype none

module sad_front
  import sad_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                     clk,
  input  wire logic                     rst,
  input  wire logic                     take,
  input  wire logic [SAMPLE_W-1:0]      sample,
  input  wire logic [COUNT_W-1:0]       target,
  output logic                          enq,
  output logic [SAMPLE_BITS+COUNT_W-1:0] enq_sum,
  output logic [COUNT_W-1:0]            enq_count
);

  localparam int SUM_W = SAMPLE_BITS + COUNT_W;
  localparam int IN_W  = (SAMPLE_BITS < SAMPLE_W) ? SAMPLE_BITS : SAMPLE_W;

  logic [SUM_W-1:0]   sample_sum;
  logic [COUNT_W-1:0] samples_taken;
  logic [SUM_W-1:0]   sum_next;
  logic [COUNT_W-1:0] taken_next;

  assign sum_next   = sample_sum + SUM_W'(sample[IN_W-1:0]);
  assign taken_next = (samples_taken == '1) ? samples_taken : samples_taken + COUNT_W'(1);
  assign enq        = take && (taken_next >= target);
  assign enq_sum    = sum_next;
  assign enq_count  = taken_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      sample_sum    <= '0;
      samples_taken <= '0;
    end else if (take) begin
      if (enq) begin
        sample_sum    <= '0;
        samples_taken <= '0;
      end else begin
        sample_sum    <= sum_next;
        samples_taken <= taken_next;
      end
    end
  end

endmodule

`default_nettype wire

### rtl/sad_back.sv
// Arithmetic back end: average, calibrated percentage and status, then the result register.
// Depends on sad_pkg and instantiates sad_div.
`default_nettype none

module sad_back
  import sad_pkg::*;
#(
  parameter int SUM_W = 20,
  parameter int DW    = 20
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               q_empty,
  input  wire logic [SUM_W-1:0]   q_sum,
  input  wire logic [COUNT_W-1:0] q_count,
  output logic                    q_pop,
  input  wire cal_t               cal,
  input  wire logic               pop,
  output logic                    empty,
  output logic [AVG_W-1:0]        raw_average,
  output logic [PCT_W-1:0]        moisture_percent,
  output logic [STATUS_W-1:0]     status
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_AVG,
    S_SCALE,
    S_PCT,
    S_OUT
  } state_t;

  state_t             state;
  logic [AVG_W-1:0]   avg;
  logic [PCT_W-1:0]   pct;
  status_t            stat;
  logic               pct_neg;
  logic               out_valid;

  logic               div_start;
  logic [DW-1:0]      div_dividend;
  logic [POINT_W-1:0] div_divisor;
  logic               div_done;
  logic [DW-1:0]      div_q;

  logic               avg_ge;
  logic               wet_ge;
  logic [POINT_W-1:0] avg_off;
  logic [POINT_W-1:0] span;
  logic [NUM_W-1:0]   num_mag;
  logic               out_free;

  assign avg_ge   = avg >= cal.dry;
  assign wet_ge   = cal.wet >= cal.dry;
  assign avg_off  = avg_ge ? avg - cal.dry : cal.dry - avg;
  assign span     = wet_ge ? cal.wet - cal.dry : cal.dry - cal.wet;
  assign num_mag  = NUM_W'(avg_off) * NUM_W'(PCT_FULL);
  assign out_free = !out_valid || pop;

  assign q_pop        = (state == S_IDLE) && !q_empty;
  assign div_start    = q_pop || (state == S_SCALE);
  assign div_dividend = (state == S_IDLE) ? DW'(q_sum) : DW'(num_mag);
  assign div_divisor  = (state == S_IDLE) ? POINT_W'(q_count) : span;

  assign empty = !out_valid;

  sad_div #(
    .DW(DW)
  ) u_div (
    .clk     (clk),
    .rst     (rst),
    .start   (div_start),
    .dividend(div_dividend),
    .divisor (div_divisor),
    .done    (div_done),
    .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      if ((state == S_OUT) && out_free) begin
        out_valid <= 1'b1;
      end else if (pop) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_pop) begin
            state <= S_AVG;
          end
        end
        S_AVG: begin
          if (div_done) begin
            avg <= div_q[AVG_W-1:0];
            pct <= '0;
            if (!cal.dry_valid || !cal.wet_valid) begin
              stat  <= STATUS_NO_CAL;
              state <= S_OUT;
            end else if (cal.dry == cal.wet) begin
              stat  <= STATUS_SAME_POINTS;
              state <= S_OUT;
            end else begin
              stat  <= STATUS_OK;
              state <= S_SCALE;
            end
          end
        end
        S_SCALE: begin
          pct_neg <= !avg_ge ^ !wet_ge;
          state   <= S_PCT;
        end
        S_PCT: begin
          if (div_done) begin
            if (pct_neg) begin
              pct <= '0;
            end else if (div_q > DW'(PCT_FULL)) begin
              pct <= PCT_FULL;
            end else begin
              pct <= div_q[PCT_W-1:0];
            end
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (out_free) begin
            raw_average      <= avg;
            moisture_percent <= pct;
            status           <= stat;
            state            <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

### rtl/sample_average_two_point_percent.sv
// Top level of the sample averaging block with two-point percent calibration.
// Holds the configuration registers; depends on sad_pkg, sad_front, sad_queue, sad_back.
//
// Samples enter through push/full; a beat is taken when push is high and full low.
// Every samples_per_average beats (0 counts as 8) one result is produced, holding
// the truncated average, the calibrated percentage (0 to 100) and a status code.
// Results leave through empty/pop; the oldest result is shown while empty is low
// and is taken when pop is high.
// The accumulator takes one sample per cycle while full is low. Each average then
// runs through a shared bit-serial divider, once for the average and, when both
// calibration points are valid and differ, once more for the percentage, one
// quotient bit per cycle; the divider is DW bits wide, DW being the larger of
// SAMPLE_BITS+8 and 19. The back end takes a new batch only when through with the last.
// A two-entry queue lies between the accumulator and the divider, so samples
// keep flowing while a result waits to be popped; once two finished batches
// wait in the queue behind the one the back end holds, full rises, blocks every
// sample and holds until the back end takes a batch from the queue.
// Reset clears the sum, the count and all queued results, and returns the
// registers to their defaults. Registers are written through write_enable.
`default_nettype none

module sample_average_two_point_percent
  import sad_pkg::*;
#(
  parameter int SAMPLE_BITS = 12
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  push,
  output logic                       full,
  input  wire logic [SAMPLE_W-1:0]   sample,
  output logic                       empty,
  input  wire logic                  pop,
  output logic [AVG_W-1:0]           raw_average,
  output logic [PCT_W-1:0]           moisture_percent,
  output logic [STATUS_W-1:0]        status,
  input  wire logic                  write_enable,
  input  wire logic [CFG_IDX_W-1:0]  write_index,
  input  wire logic [CFG_DATA_W-1:0] write_data
);

  localparam int SUM_W = SAMPLE_BITS + COUNT_W;
  localparam int DW    = (SUM_W > NUM_W) ? SUM_W : NUM_W;
  localparam int QW    = SUM_W + COUNT_W;

  logic [COUNT_W-1:0] samples_per_average;
  cal_t               cal;
  logic [COUNT_W-1:0] target;

  logic               take;
  logic               enq;
  logic [SUM_W-1:0]   enq_sum;
  logic [COUNT_W-1:0] enq_count;
  logic [QW-1:0]      q_rd_data;
  logic               q_pop;
  logic               q_full;
  logic               q_empty;

  assign target = (samples_per_average == '0) ? COUNT_DEFAULT : samples_per_average;
  assign full   = q_full;
  assign take   = push && !q_full;

  always_ff @(posedge clk) begin
    if (rst) begin
      samples_per_average <= COUNT_DEFAULT;
      cal.dry             <= '0;
      cal.wet             <= '0;
      cal.dry_valid       <= 1'b0;
      cal.wet_valid       <= 1'b0;
    end else if (write_enable) begin
      unique case (write_index)
        REG_SAMPLES:   samples_per_average <= write_data[COUNT_W-1:0];
        REG_DRY:       cal.dry             <= write_data[POINT_W-1:0];
        REG_WET:       cal.wet             <= write_data[POINT_W-1:0];
        REG_DRY_VALID: cal.dry_valid       <= write_data[0];
        REG_WET_VALID: cal.wet_valid       <= write_data[0];
        default: begin
        end
      endcase
    end
  end

  sad_front #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .take     (take),
    .sample   (sample),
    .target   (target),
    .enq      (enq),
    .enq_sum  (enq_sum),
    .enq_count(enq_count)
  );

  sad_queue #(
    .W(QW)
  ) u_queue (
    .clk    (clk),
    .rst    (rst),
    .wr_en  (enq),
    .wr_data({enq_sum, enq_count}),
    .rd_en  (q_pop),
    .rd_data(q_rd_data),
    .full   (q_full),
    .empty  (q_empty)
  );

  sad_back #(
    .SUM_W(SUM_W),
    .DW   (DW)
  ) u_back (
    .clk             (clk),
    .rst             (rst),
    .q_empty         (q_empty),
    .q_sum           (q_rd_data[QW-1:COUNT_W]),
    .q_count         (q_rd_data[COUNT_W-1:0]),
    .q_pop           (q_pop),
    .cal             (cal),
    .pop             (pop),
    .empty           (empty),
    .raw_average     (raw_average),
    .moisture_percent(moisture_percent),
    .status          (status)
  );

endmodule

`default_nettype wire
